FILE: rtl/pqfs_pkg.sv
// shared constants and helpers for the pq fast-scan lookup block
`default_nettype none

package pqfs_pkg;

	localparam int NUM_VECTORS = 32;
	localparam int IDX_W       = $clog2(NUM_VECTORS);
	localparam int SUM_WIDTH   = 16;
	localparam int DIST_W      = 8;
	localparam int CODE_W      = 4;
	localparam int WORD_W      = 64;
	localparam int TBL_ENTRIES = 16;
	localparam int CODE_BYTES  = 16;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VECTORS - 1);

	typedef logic [SUM_WIDTH-1:0] sum_t;
	typedef logic [DIST_W-1:0]    dist_t;
	typedef logic [CODE_W-1:0]    code_t;

	// code byte that holds the nibble of vector r
	function automatic logic [3:0] code_byte_of(input logic [IDX_W-1:0] r);
		return {r[2:0], r[3]};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pqfs_if.sv
// valid/ready channel interfaces for subspace items and sum items
`default_nettype none

interface pqfs_in_if;
	import pqfs_pkg::*;
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   table_low;
	logic [WORD_W-1:0]   table_high;
	logic [WORD_W-1:0]   codes_low;
	logic [WORD_W-1:0]   codes_high;
	logic                last_subspace;

	modport source (output valid, table_low, table_high, codes_low, codes_high,
		last_subspace, input ready);
	modport sink (input valid, table_low, table_high, codes_low, codes_high,
		last_subspace, output ready);
endinterface

interface pqfs_out_if;
	import pqfs_pkg::*;
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    vector_index;
	logic [SUM_WIDTH-1:0] partial_sum;
	logic                last_of_run;

	modport source (output valid, vector_index, partial_sum, last_of_run,
		input ready);
	modport sink (input valid, vector_index, partial_sum, last_of_run,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/pqfs_lookup.sv
// 32 parallel 4-bit code lookups into a 16-entry distance table
`default_nettype none

module pqfs_lookup
	import pqfs_pkg::*;
(
	input  wire logic [TBL_ENTRIES*DIST_W-1:0]       dist_table,
	input  wire logic [CODE_BYTES*8-1:0]             codes,
	output      dist_t [NUM_VECTORS-1:0]             dist_sel
);

	always_comb begin
		logic [3:0] b;
		logic [7:0] cb;
		code_t      code;
		for (int r = 0; r < NUM_VECTORS; r++) begin
			b    = code_byte_of(IDX_W'(r));
			cb   = codes[8*b +: 8];
			// low nibble for the first half of the vectors, high nibble after
			code = (r < NUM_VECTORS / 2) ? cb[3:0] : cb[7:4];
			dist_sel[r] = dist_table[DIST_W*code +: DIST_W];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pq_fast_scan_lookup_accumulate.sv
// top level: pq fast-scan lookup, per-vector accumulation and sum readout
// order: an item taken into the input register updates the sums as it advances;
//   on a last subspace the final sums go to a snapshot, then to the output register
// throughput: one subspace item per cycle unless a last one is held; a last subspace
//   streams 32 sums, one per ready cycle, from a snapshot while accumulation goes on
// a second last subspace waits in the input register until the snapshot frees
// reset clears the 32 running sums and all valid/busy flags at once
`default_nettype none

module pq_fast_scan_lookup_accumulate
	import pqfs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	pqfs_in_if.sink     in,
	pqfs_out_if.source  out
);

	// input register stage
	logic                         valid_s1;
	logic [2*WORD_W-1:0]          table_s1;
	logic [2*WORD_W-1:0]          codes_s1;
	logic                         last_s1;

	// running sums and the readout snapshot
	sum_t                         sums_q [NUM_VECTORS];
	sum_t                         sums_next [NUM_VECTORS];
	sum_t                         dump_q [NUM_VECTORS];
	logic                         dump_busy_q;
	logic [IDX_W-1:0]             dump_idx_q;

	// output register
	logic                         out_valid_q;
	logic [IDX_W-1:0]             out_idx_q;
	sum_t                         out_sum_q;
	logic                         out_last_q;

	dist_t [NUM_VECTORS-1:0]      dist_sel;
	logic                         out_load;
	logic                         dump_free;
	logic                         advance;
	logic                         in_ready;

	// snapshot can take a new run when idle or when its final sum leaves now
	assign out_load  = dump_busy_q && (!out_valid_q || out.ready);
	assign dump_free = !dump_busy_q || (out_load && dump_idx_q == LAST_IDX);
	// a last subspace holds in the input register until the snapshot is free
	assign advance   = valid_s1 && (!last_s1 || dump_free);
	assign in_ready  = !valid_s1 || advance;
	assign in.ready  = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in_ready) begin
			table_s1 <= {in.table_high, in.table_low};
			codes_s1 <= {in.codes_high, in.codes_low};
			last_s1  <= in.last_subspace;
		end
	end

	pqfs_lookup u_lookup (
		.dist_table (table_s1),
		.codes      (codes_s1),
		.dist_sel   (dist_sel)
	);

	// each sum wraps on its own, no carry between lanes
	always_comb begin
		for (int r = 0; r < NUM_VECTORS; r++) begin
			sums_next[r] = sums_q[r] + {{(SUM_WIDTH-DIST_W){1'b0}}, dist_sel[r]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_VECTORS; r++) begin
				sums_q[r] <= '0;
			end
		end else if (advance) begin
			for (int r = 0; r < NUM_VECTORS; r++) begin
				sums_q[r] <= last_s1 ? '0 : sums_next[r];
			end
		end
	end

	// snapshot of the final sums of a run
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			for (int r = 0; r < NUM_VECTORS; r++) begin
				dump_q[r] <= sums_next[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_busy_q <= 1'b0;
			dump_idx_q  <= '0;
		end else begin
			if (advance && last_s1) begin
				dump_busy_q <= 1'b1;
			end else if (out_load && dump_idx_q == LAST_IDX) begin
				dump_busy_q <= 1'b0;
			end
			// index wraps back to zero after vector 31
			if (out_load) begin
				dump_idx_q <= dump_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= dump_idx_q;
			out_sum_q  <= dump_q[dump_idx_q];
			out_last_q <= (dump_idx_q == LAST_IDX);
		end
	end

	assign out.valid        = out_valid_q;
	assign out.vector_index = out_idx_q;
	assign out.partial_sum  = out_sum_q;
	assign out.last_of_run  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/pqfs_checker.sv
// port-level checks on the sum stream of the fast-scan block
`default_nettype none

module pqfs_checker
	import pqfs_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [IDX_W-1:0]     out_vector_index,
	input wire logic [SUM_WIDTH-1:0] out_partial_sum,
	input wire logic                 out_last_of_run
);

	logic [IDX_W-1:0] exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= exp_idx_q + 1'b1;
		end
	end

	// sums leave in index order, each run starting at vector 0
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_vector_index == exp_idx_q)
		else $error("sum item out of index order");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last_of_run == (out_vector_index == LAST_IDX)))
		else $error("last_of_run does not match vector 31");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("sum item dropped while stalled");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_partial_sum))
		else $error("sum changed while stalled");

endmodule

bind pq_fast_scan_lookup_accumulate pqfs_checker u_pqfs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out.valid),
	.out_ready        (out.ready),
	.out_vector_index (out.vector_index),
	.out_partial_sum  (out.partial_sum),
	.out_last_of_run  (out.last_of_run)
);

`default_nettype wire

FILE: bench/tb.sv
// testbench for pq_fast_scan_lookup_accumulate: lookup sums against a local predictor
`timescale 1ns / 1ps

module tb;
	import pqfs_pkg::*;

	// one subspace item as the sender drives it
	typedef struct packed {
		logic [WORD_W-1:0] table_low;
		logic [WORD_W-1:0] table_high;
		logic [WORD_W-1:0] codes_low;
		logic [WORD_W-1:0] codes_high;
		logic              last_subspace;
	} subspace_t;

	// one sum item as the block should emit it
	typedef struct packed {
		logic [IDX_W-1:0] vector_index;
		sum_t             partial_sum;
		logic             last_of_run;
	} sum_item_t;

	// receiver stall patterns, switched at random
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	// idle cycles with no item moving on either side before giving up
	localparam int IDLE_LIMIT = 2000;
	// cycles to watch for stray sums once everything has come back
	localparam int TAIL_CYCLES = 40;

	logic clk;
	logic arst_n;

	pqfs_in_if  in_ch();
	pqfs_out_if out_ch();

	pq_fast_scan_lookup_accumulate u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	// predictor state: the 32 running sums, wrapping at the sum width
	sum_t      running_sum [NUM_VECTORS];
	sum_item_t expected_sums [$];

	int unsigned items_sent;
	int unsigned runs_sent;
	int unsigned sums_checked;
	int unsigned errors;
	int unsigned idle_cycles;

	// sender burst control
	int unsigned burst_left;
	bit          gaps_on;

	// receiver stall control
	stall_mode_t stall_mode;
	int unsigned stall_left;
	int unsigned stall_tick;

	always #4 clk = ~clk;

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------

	// vector r reads code byte 2*(r mod 8) + (r/8 mod 2): low nibble for
	// r < 16, high nibble above; the nibble picks one 8-bit table entry
	function automatic void accumulate_subspace(input subspace_t s);
		logic [2*WORD_W-1:0] codes;
		logic [2*WORD_W-1:0] dists;
		logic [7:0]          code_byte;
		logic [3:0]          nibble;
		int                  byte_sel;
		sum_item_t           res;
		codes = {s.codes_high, s.codes_low};
		dists = {s.table_high, s.table_low};
		for (int r = 0; r < NUM_VECTORS; r++) begin
			byte_sel = 2 * (r % 8) + ((r / 8) % 2);
			code_byte = codes[8*byte_sel +: 8];
			nibble = (r < 16) ? code_byte[3:0] : code_byte[7:4];
			running_sum[r] = running_sum[r] + sum_t'(dists[8*nibble +: 8]);
		end
		// last subspace: this item counts, then all sums go out and clear
		if (s.last_subspace) begin
			for (int r = 0; r < NUM_VECTORS; r++) begin
				res.vector_index = IDX_W'(r);
				res.partial_sum  = running_sum[r];
				res.last_of_run  = (r == NUM_VECTORS - 1);
				expected_sums.push_back(res);
				running_sum[r] = '0;
			end
		end
	endfunction

	// ---------------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------------

	// drives one subspace item and waits for its handshake; valid stays high
	// into the next call unless a gap is taken there
	task automatic send_subspace(input subspace_t s);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 80)
				: $urandom_range(1, 12);
			if (gaps_on)
				gap = $urandom_range(1, 6);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.table_low     <= s.table_low;
		in_ch.table_high    <= s.table_high;
		in_ch.codes_low     <= s.codes_low;
		in_ch.codes_high    <= s.codes_high;
		in_ch.last_subspace <= s.last_subspace;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		accumulate_subspace(s);
		items_sent++;
		if (s.last_subspace)
			runs_sent++;
	endtask

	// sender holds off until every pending sum has come back
	task automatic pause_until_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		// accumulation of the item just taken may still be in flight
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// random 64-bit word, biased toward all-zero, all-one, one-hot and one-cold values
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			end
			3: begin
				return ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
			end
			default: begin
				return {$urandom, $urandom};
			end
		endcase
	endfunction

	function automatic subspace_t pick_subspace(input logic last);
		subspace_t s;
		s.table_low     = pick_word();
		s.table_high    = pick_word();
		s.codes_low     = pick_word();
		s.codes_high    = pick_word();
		s.last_subspace = last;
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// receiver side: stall patterns that change at random
	// ---------------------------------------------------------------------

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE: begin
				out_ch.ready <= 1'b1;
			end
			STALL_LIGHT: begin
				out_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			STALL_PERIODIC: begin
				out_ch.ready <= (stall_tick % 5) < 3;
			end
			default: begin
				out_ch.ready <= ($urandom_range(0, 4) == 0);
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("mismatch at %0t: %s want 0x%0h got 0x%0h", $time, what, want, got);
		errors++;
	endtask

	// each sum item taken is compared with the oldest one predicted
	always @(posedge clk) begin
		sum_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_sums.size() == 0) begin
				report_mismatch("sum item with none pending, index", '0,
					32'(out_ch.vector_index));
			end else begin
				want = expected_sums.pop_front();
				if (out_ch.vector_index !== want.vector_index)
					report_mismatch("vector_index", 32'(want.vector_index),
						32'(out_ch.vector_index));
				if (out_ch.partial_sum !== want.partial_sum)
					report_mismatch($sformatf("partial_sum of vector %0d",
						want.vector_index), 32'(want.partial_sum),
						32'(out_ch.partial_sum));
				if (out_ch.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run of vector %0d",
						want.vector_index), 32'(want.last_of_run),
						32'(out_ch.last_of_run));
			end
			sums_checked++;
		end
	end

	// watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles, %0d sums pending",
				IDLE_LIMIT, expected_sums.size());
			$display("pq_fast_scan_lookup_accumulate test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// first item after reset: sums must start from zero, so each sum is
	// just the entry its code selects
	task automatic test_reset_state();
		subspace_t s;
		s.table_low     = 64'h7766_5544_3322_1100;
		s.table_high    = 64'hFFEE_DDCC_BBAA_9988;
		s.codes_low     = 64'h7654_3210_FEDC_BA98;
		s.codes_high    = 64'h0F1E_2D3C_4B5A_6978;
		s.last_subspace = 1'b1;
		send_subspace(s);
	endtask

	// distinct table entries make every code byte and nibble choice visible
	task automatic test_code_mapping();
		subspace_t s;
		s.table_low  = 64'h7766_5544_3322_1100;
		s.table_high = 64'hFFEE_DDCC_BBAA_9988;
		s.last_subspace = 1'b1;
		// nibble patterns: ramps, swapped halves, extremes, single lanes
		for (int k = 0; k < 8; k++) begin
			case (k)
				0: begin
					s.codes_low  = 64'h0000_0000_0000_0000;
					s.codes_high = 64'h0000_0000_0000_0000;
				end
				1: begin
					s.codes_low  = 64'hFFFF_FFFF_FFFF_FFFF;
					s.codes_high = 64'hFFFF_FFFF_FFFF_FFFF;
				end
				2: begin
					s.codes_low  = 64'h0F0F_0F0F_0F0F_0F0F;
					s.codes_high = 64'hF0F0_F0F0_F0F0_F0F0;
				end
				3: begin
					s.codes_low  = 64'h7163_5247_3425_1603;
					s.codes_high = 64'hF8EA_DCCE_BAAC_9E8F;
				end
				4: begin
					s.codes_low  = 64'h0000_0000_0000_00F5;
					s.codes_high = 64'hA000_0000_0000_0000;
				end
				5: begin
					s.codes_low  = 64'h0123_4567_89AB_CDEF;
					s.codes_high = 64'hFEDC_BA98_7654_3210;
				end
				6: begin
					s.codes_low  = 64'h5A5A_5A5A_5A5A_5A5A;
					s.codes_high = 64'hA5A5_A5A5_A5A5_A5A5;
				end
				default: begin
					s.codes_low  = 64'hC3D2_E1F0_8796_A5B4;
					s.codes_high = 64'h4B5A_6978_0F1E_2D3C;
				end
			endcase
			send_subspace(s);
		end
	endtask

	// several subspaces that only accumulate, then one that emits; largest
	// and smallest entries mixed
	task automatic test_accumulate_then_emit();
		subspace_t s;
		for (int k = 0; k < 5; k++) begin
			s.table_low     = (k % 2) ? '1 : 64'h0102_0408_1020_4080;
			s.table_high    = (k % 2) ? 64'h0 : '1;
			s.codes_low     = {$urandom, $urandom};
			s.codes_high    = {$urandom, $urandom};
			s.last_subspace = (k == 4);
			send_subspace(s);
		end
	endtask

	// emitting items one after another with no gaps: the second must wait
	// until the sums of the first have streamed out
	task automatic test_back_to_back_runs();
		gaps_on = 1'b0;
		burst_left = 8;
		send_subspace(pick_subspace(1'b1));
		send_subspace(pick_subspace(1'b1));
		send_subspace(pick_subspace(1'b0));
		send_subspace(pick_subspace(1'b1));
		gaps_on = 1'b1;
	endtask

	// long run of near-maximum entries so every sum wraps past 65535
	task automatic test_sum_wrap();
		subspace_t s;
		for (int k = 0; k < 280; k++) begin
			for (int b = 0; b < 8; b++) begin
				s.table_low[8*b +: 8]  = 8'hF8 | 8'($urandom_range(0, 7));
				s.table_high[8*b +: 8] = 8'hF8 | 8'($urandom_range(0, 7));
			end
			s.codes_low     = {$urandom, $urandom};
			s.codes_high    = {$urandom, $urandom};
			s.last_subspace = (k == 279);
			send_subspace(s);
		end
	endtask

	// random runs of random length, mostly short, with a hold-off midway
	task automatic test_random_runs(input int unsigned count);
		int unsigned sent;
		int unsigned run_len;
		sent = 0;
		while (sent < count) begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
				: $urandom_range(1, 8);
			for (int k = 0; k < run_len; k++)
				send_subspace(pick_subspace(k == run_len - 1));
			sent += run_len;
			if (sent >= count / 2 && sent - run_len < count / 2)
				pause_until_drained();
		end
	endtask

	// ---------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.table_low = '0;
		in_ch.table_high = '0;
		in_ch.codes_low = '0;
		in_ch.codes_high = '0;
		in_ch.last_subspace = 1'b0;
		out_ch.ready = 1'b0;
		items_sent = 0;
		runs_sent = 0;
		sums_checked = 0;
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		stall_mode = STALL_NONE;
		stall_left = 0;
		stall_tick = 0;
		for (int r = 0; r < NUM_VECTORS; r++)
			running_sum[r] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_code_mapping();
		test_accumulate_then_emit();
		test_back_to_back_runs();
		pause_until_drained();
		test_sum_wrap();
		test_random_runs(190);

		// the stimulus ends on an emitting item so no partial run is left
		send_subspace(pick_subspace(1'b1));
		@(negedge clk);
		in_ch.valid <= 1'b0;

		while (expected_sums.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d subspace items in %0d emitting runs, %0d sums checked",
			items_sent, runs_sent, sums_checked);
		$display("including wrapped sums, back-to-back emits and random stalls, %0d errors",
			errors);
		if (errors == 0 && expected_sums.size() == 0) begin
			$display("pq_fast_scan_lookup_accumulate test passed");
		end else begin
			$display("pq_fast_scan_lookup_accumulate test failed");
		end
		$finish;
	end

endmodule
